@@ rtl/ltfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ltfd_pkg
// Types and constants shared by the length/type frame deframer modules.
// ----------------------------------------------------------------------------
package ltfd_pkg;

   // Header layout: 4 length bytes, then 2 type bytes
   localparam int unsigned LEN_BYTES    = 4;
   localparam int unsigned HEADER_BYTES = 4 + 2;
   localparam logic [31:0] MIN_LEN      = 32'd2;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_BODY   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] msg_type;
      logic [31:0] body_length;
      logic [7:0]  body_byte;
      logic        frame_last;
   } rsp_item_type;

endpackage

@@ rtl/ltfd_parse.sv @@
// ----------------------------------------------------------------------------
// ltfd_parse
// Frame parser: holds the header, body and drop state and turns one input
// beat into at most one result beat.
// ----------------------------------------------------------------------------
module ltfd_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ltfd_pkg::req_item_type item,
   output logic                  res_valid,
   output ltfd_pkg::rsp_item_type res
);
   import ltfd_pkg::*;

   logic [2:0]  header_count_ff, header_count_in;
   logic [31:0] length_word_ff, length_word_in;
   logic [15:0] type_word_ff, type_word_in;
   logic [31:0] body_remaining_ff, body_remaining_in;
   logic        in_body_ff, in_body_in;
   logic        dropping_ff, dropping_in;

   logic [31:0] remaining_dec;
   logic [31:0] body_len;
   logic [2:0]  count_inc;

   assign remaining_dec = body_remaining_ff - 32'd1;
   assign body_len      = length_word_ff - MIN_LEN;
   assign count_inc     = header_count_ff + 3'd1;

   // Work out the next state and the result for the current beat
   always_comb begin
      header_count_in   = header_count_ff;
      length_word_in    = length_word_ff;
      type_word_in      = type_word_ff;
      body_remaining_in = body_remaining_ff;
      in_body_in        = in_body_ff;
      dropping_in       = dropping_ff;
      res_valid         = 1'b0;
      res               = '0;

      if (dropping_ff) begin
         // Discard bytes up to and including the chunk end
         if (item.chunk_end) begin
            dropping_in = 1'b0;
         end
      end else if (in_body_ff) begin
         // Pass a body byte and mark the last one
         body_remaining_in = remaining_dec;
         res_valid         = 1'b1;
         res.result_kind   = KIND_BODY;
         res.body_byte     = item.data_byte;
         res.frame_last    = (remaining_dec == 32'd0);
         if (remaining_dec == 32'd0) begin
            in_body_in = 1'b0;
         end
      end else if (header_count_ff < 3'(LEN_BYTES)) begin
         // Shift in a length byte
         length_word_in  = {length_word_ff[23:0], item.data_byte};
         header_count_in = count_inc;
      end else begin
         // Shift in a type byte; the last header byte closes the header
         type_word_in    = {type_word_ff[7:0], item.data_byte};
         header_count_in = count_inc;
         if (count_inc == 3'(HEADER_BYTES)) begin
            header_count_in = 3'd0;
            res_valid       = 1'b1;
            if (length_word_ff < MIN_LEN) begin
               dropping_in     = !item.chunk_end;
               res.result_kind = KIND_ERROR;
            end else begin
               body_remaining_in = body_len;
               in_body_in        = (body_len != 32'd0);
               res.result_kind   = KIND_HEADER;
               res.msg_type      = {type_word_ff[7:0], item.data_byte};
               res.body_length   = body_len;
               res.frame_last    = (body_len == 32'd0);
            end
         end
      end
   end

   // Advance state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff   <= 3'd0;
         length_word_ff    <= 32'd0;
         type_word_ff      <= 16'd0;
         body_remaining_ff <= 32'd0;
         in_body_ff        <= 1'b0;
         dropping_ff       <= 1'b0;
      end else if (step) begin
         header_count_ff   <= header_count_in;
         length_word_ff    <= length_word_in;
         type_word_ff      <= type_word_in;
         body_remaining_ff <= body_remaining_in;
         in_body_ff        <= in_body_in;
         dropping_ff       <= dropping_in;
      end
   end

endmodule

@@ rtl/ltfd_out.sv @@
// ----------------------------------------------------------------------------
// ltfd_out
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ltfd_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ltfd_pkg::rsp_item_type res,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ltfd_pkg::rsp_item_type rsp_item
);
   import ltfd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Free when empty or when the held beat leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result beat
   always_ff @(posedge clock) begin
      if (ready && load) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ rtl/length_type_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// length_type_frame_deframer
// Splits a byte stream into frames of 4-byte length, 2-byte type and body,
// reporting headers, body bytes and invalid-length errors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | data_byte, chunk_end
//  rsp     | out       | rsp_valid/rsp_stall  | result_kind, msg_type,
//          |           |                      | body_length, body_byte,
//          |           |                      | frame_last
//
//  One byte beat per cycle while rsp is not stalled; a result is offered on
//  rsp once its byte has passed the input register, then the result register.
//  Reset clears the parse state and both valid registers.
//  A stalled result holds the input register, which then stalls req.
// ----------------------------------------------------------------------------
module length_type_frame_deframer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ltfd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ltfd_pkg::rsp_item_type rsp_item
);
   import ltfd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_ready;
   logic         advance;
   logic         take;
   logic         res_valid;
   rsp_item_type res;

   // Process the held byte whenever the result register is free
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the incoming beat
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
   end

   ltfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   ltfd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .res       (res),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
